@@ design/sma_pkg.sv @@
// shared types, constants and table builder for the sudoku annealer
`default_nettype none
package sma_pkg;

   localparam int EnergyW = 10;
   localparam int ValueW  = 5;
   localparam int CoordW  = 4;
   localparam int ProbW   = 16;
   localparam int TempW   = 16;
   localparam int ProbMaxDepth = 1024;
   localparam logic [63:0] ExpStepMult = 64'd4034748382;

   typedef enum logic {
      CSR_INV_TEMP = 1'b0,
      CSR_STOP     = 1'b1
   } csr_idx_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_PROPOSE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_scan;
      logic issue;
      logic evaluate;
      logic decide;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic skip;
      logic scan_last;
   } status_type;

   typedef logic [ProbW-1:0] prob_arr_type [ProbMaxDepth];

   // exp(-k/16) chain in q0.32, rounded to q0.16 and saturated
   function automatic prob_arr_type build_prob();
      prob_arr_type tbl;
      logic [95:0]  p;
      logic [95:0]  q;
      logic [95:0]  t;
      p = 96'd1 << 32;
      for (int k = 0; k < ProbMaxDepth; k++) begin
         q = (p + 96'd32768) >> 16;
         tbl[k] = (q > 96'd65535) ? 16'hFFFF : q[15:0];
         t = p * {32'd0, ExpStepMult} + (96'd1 << 31);
         p = t >> 32;
      end
      return tbl;
   endfunction

endpackage
`default_nettype wire

@@ design/sma_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module sma_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 81
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

@@ design/sma_ctrl.sv @@
// sequencing state machine of the annealer
`default_nettype none
module sma_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sma_pkg::cmd_type        cmd,
   input  wire sma_pkg::status_type status
);
   import sma_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_CHECK;
         ST_CHECK:  state_in = status.skip ? ST_FINISH : ST_SCAN;
         ST_SCAN:   if (status.scan_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_FINISH;
         ST_FINISH: if (cmd.commit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:   cmd.capture = req_valid;
         ST_CHECK:  cmd.clear_scan = 1'b1;
         ST_SCAN:   cmd.issue = 1'b1;
         ST_EVAL:   cmd.evaluate = 1'b1;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_FINISH: cmd.commit = !rsp_valid_ff || !rsp_stall;
         default:   cmd = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_CHECK)
      else $error("accepted beat did not start a check");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a stalled beat");
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");
endmodule
`default_nettype wire

@@ design/sma_datapath.sv @@
// grid store, energy scan, acceptance test and result register
`default_nettype none
module sma_datapath #(
   parameter int BOX_SIZE        = 3,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sma_pkg::cmd_type                cmd,
   output sma_pkg::status_type                  status,
   input  wire logic                            req_op,
   input  wire logic [sma_pkg::CoordW-1:0]      req_row,
   input  wire logic [sma_pkg::CoordW-1:0]      req_col,
   input  wire logic [sma_pkg::ValueW-1:0]      req_value,
   input  wire logic [sma_pkg::ProbW-1:0]       req_uniform,
   input  wire logic                            csr_write_enable,
   input  wire logic                            csr_index,
   input  wire logic [sma_pkg::TempW-1:0]       csr_write_data,
   output logic      [sma_pkg::EnergyW-1:0]     rsp_energy,
   output logic                                 rsp_accepted,
   output logic                                 rsp_solved,
   output logic                                 rsp_bad_input
);
   import sma_pkg::*;

   localparam int Side  = BOX_SIZE * BOX_SIZE;
   localparam int Cells = Side * Side;
   localparam int AW    = $clog2(Cells);
   localparam int IW    = $clog2(Side);
   localparam int BW    = (BOX_SIZE > 1) ? $clog2(BOX_SIZE) : 1;
   localparam int ResetEnergy = 3 * Side * (Side - 1);
   localparam prob_arr_type ProbTbl = build_prob();
   localparam int XW = EnergyW + TempW;
   localparam int KW = XW - 8;

   // configuration
   logic [TempW-1:0] inv_temp_ff;
   logic             stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_temp_ff <= TempW'(4096);
         stop_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_INV_TEMP: inv_temp_ff <= csr_write_data;
            CSR_STOP:     stop_ff     <= csr_write_data[0];
            default:      ;
         endcase
      end
   end

   // captured item
   logic               op_ff;
   logic [ValueW-1:0]  value_ff;
   logic [ProbW-1:0]   uniform_ff;
   logic [AW-1:0]      tgt_ff;
   logic               bad_ff, skip_ff;
   logic [EnergyW-1:0] energy_ff;
   logic               bad_in;

   assign bad_in = ({1'b0, req_row} >= 5'(Side)) || ({1'b0, req_col} >= 5'(Side))
                || (req_value == '0) || (req_value > ValueW'(Side));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         value_ff   <= req_value;
         uniform_ff <= req_uniform;
         tgt_ff     <= AW'(32'(req_row) * Side + 32'(req_col));
         bad_ff     <= bad_in;
         skip_ff    <= bad_in || (op_type'(req_op) == OP_PROPOSE && stop_ff
                                  && energy_ff == '0);
      end
   end

   // scan counters
   logic [AW-1:0] sc_addr_ff;
   logic [IW-1:0] sc_r_ff, sc_c_ff;
   logic [BW-1:0] cb_ff, bx_ff, rb_ff, by_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_scan) begin
         sc_addr_ff <= '0;
         sc_r_ff    <= '0;
         sc_c_ff    <= '0;
         cb_ff      <= '0;
         bx_ff      <= '0;
         rb_ff      <= '0;
         by_ff      <= '0;
      end else if (cmd.issue) begin
         sc_addr_ff <= sc_addr_ff + 1'b1;
         if (sc_c_ff == IW'(Side - 1)) begin
            sc_c_ff <= '0;
            cb_ff   <= '0;
            bx_ff   <= '0;
            sc_r_ff <= sc_r_ff + 1'b1;
            if (rb_ff == BW'(BOX_SIZE - 1)) begin
               rb_ff <= '0;
               by_ff <= by_ff + 1'b1;
            end else begin
               rb_ff <= rb_ff + 1'b1;
            end
         end else begin
            sc_c_ff <= sc_c_ff + 1'b1;
            if (cb_ff == BW'(BOX_SIZE - 1)) begin
               cb_ff <= '0;
               bx_ff <= bx_ff + 1'b1;
            end else begin
               cb_ff <= cb_ff + 1'b1;
            end
         end
      end
   end

   assign status.scan_last = (sc_addr_ff == AW'(Cells - 1));
   assign status.skip      = skip_ff;

   // cell store, never-written cells read as one
   logic              ram_we;
   logic [ValueW-1:0] ram_q;
   logic              cell_vld_ff [Cells];

   sma_ram #(.WIDTH(ValueW), .DEPTH(Cells)) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (tgt_ff),
      .wdata (value_ff),
      .raddr (sc_addr_ff),
      .rdata (ram_q)
   );

   // read stage
   logic          d_valid_ff, d_vld_ff;
   logic [AW-1:0] d_addr_ff;
   logic [IW-1:0] d_r_ff, d_c_ff, d_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= cmd.issue;
      end
      d_vld_ff  <= cell_vld_ff[sc_addr_ff];
      d_addr_ff <= sc_addr_ff;
      d_r_ff    <= sc_r_ff;
      d_c_ff    <= sc_c_ff;
      d_b_ff    <= IW'(32'(by_ff) * BOX_SIZE + 32'(bx_ff));
   end

   // duplicate counting with seen maps
   logic [Side-1:0]    seen_row_ff [Side];
   logic [Side-1:0]    seen_col_ff [Side];
   logic [Side-1:0]    seen_box_ff [Side];
   logic [EnergyW-1:0] errors_ff;
   logic [ValueW-1:0]  cell_v;
   logic [ValueW-1:0]  cell_m1;
   logic [IW-1:0]      bit_idx;
   logic               hit_r, hit_c, hit_b;

   always_comb begin
      if (d_addr_ff == tgt_ff) begin
         cell_v = value_ff;
      end else if (d_vld_ff) begin
         cell_v = ram_q;
      end else begin
         cell_v = ValueW'(1);
      end
      cell_m1 = cell_v - 1'b1;
      bit_idx = cell_m1[IW-1:0];
      hit_r   = seen_row_ff[d_r_ff][bit_idx];
      hit_c   = seen_col_ff[d_c_ff][bit_idx];
      hit_b   = seen_box_ff[d_b_ff][bit_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_scan) begin
         errors_ff <= '0;
         for (int i = 0; i < Side; i++) begin
            seen_row_ff[i] <= '0;
            seen_col_ff[i] <= '0;
            seen_box_ff[i] <= '0;
         end
      end else if (d_valid_ff) begin
         errors_ff <= errors_ff + EnergyW'(hit_r) + EnergyW'(hit_c) + EnergyW'(hit_b);
         seen_row_ff[d_r_ff][bit_idx] <= 1'b1;
         seen_col_ff[d_c_ff][bit_idx] <= 1'b1;
         seen_box_ff[d_b_ff][bit_idx] <= 1'b1;
      end
   end

   // acceptance test
   logic               drop_ff, accept_ff;
   logic [EnergyW-1:0] new_ff;
   logic [XW-1:0]      x_ff;
   logic [EnergyW-1:0] de;
   logic [KW-1:0]      k_idx;
   logic [ProbW-1:0]   prob;

   assign de    = errors_ff - energy_ff;
   assign k_idx = x_ff[XW-1:8];
   assign prob  = (k_idx < KW'(EXP_TABLE_DEPTH)) ? ProbTbl[k_idx[$clog2(ProbMaxDepth)-1:0]]
                                                : '0;

   always_ff @(posedge clock) begin
      if (cmd.evaluate) begin
         new_ff  <= errors_ff;
         drop_ff <= (errors_ff <= energy_ff);
         x_ff    <= XW'(de) * XW'(inv_temp_ff);
      end
      if (cmd.capture) begin
         accept_ff <= 1'b0;
      end else if (cmd.decide) begin
         accept_ff <= (op_type'(op_ff) == OP_LOAD) || drop_ff || (uniform_ff <= prob);
      end
   end

   // commit
   assign ram_we = cmd.commit && accept_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff <= EnergyW'(ResetEnergy);
         for (int i = 0; i < Cells; i++) begin
            cell_vld_ff[i] <= 1'b0;
         end
      end else if (ram_we) begin
         energy_ff           <= new_ff;
         cell_vld_ff[tgt_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_energy    <= accept_ff ? new_ff : energy_ff;
         rsp_solved    <= accept_ff ? (new_ff == '0) : (energy_ff == '0);
         rsp_accepted  <= accept_ff;
         rsp_bad_input <= bad_ff;
      end
   end
endmodule
`default_nettype wire

@@ design/sudoku_metropolis_annealer.sv @@
// a beat runs from the accepting edge to the result register through check, the one-cell-a-cycle
// energy scan, drain, evaluate, decide and finish
// one beat at a time; the next is taken once the result is registered
// out-of-range and frozen beats skip the scan and go from check straight to finish
// reset: synchronous, grid reads as all ones, energy 3*SIDE*(SIDE-1), inverse temp 1.0
// the result register holds one beat, so a stalled result holds the next beat in finish until it is taken
`default_nettype none
module sudoku_metropolis_annealer #(
   parameter int BOX_SIZE        = 3,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_op,
   input  wire logic [sma_pkg::CoordW-1:0]      req_row,
   input  wire logic [sma_pkg::CoordW-1:0]      req_col,
   input  wire logic [sma_pkg::ValueW-1:0]      req_value,
   input  wire logic [sma_pkg::ProbW-1:0]       req_uniform,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [sma_pkg::EnergyW-1:0]     rsp_energy,
   output logic                                 rsp_accepted,
   output logic                                 rsp_solved,
   output logic                                 rsp_bad_input,
   input  wire logic                            csr_write_enable,
   input  wire logic                            csr_index,
   input  wire logic [sma_pkg::TempW-1:0]       csr_write_data
);
   import sma_pkg::*;

   cmd_type    cmd;
   status_type status;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   sma_datapath #(
      .BOX_SIZE        (BOX_SIZE),
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .req_uniform      (req_uniform),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_energy       (rsp_energy),
      .rsp_accepted     (rsp_accepted),
      .rsp_solved       (rsp_solved),
      .rsp_bad_input    (rsp_bad_input)
   );
endmodule
`default_nettype wire
